@@ rtl/json_string_unescape_utf8_macros.svh @@
// Assertion macros used by the result register of the string unescaper RTL.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/jsu_pkg.sv @@
// Types and constants of the JSON string unescaper.
package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_STR     = 3'd1,
        MODE_ESC     = 3'd2,
        MODE_HEX1    = 3'd3,
        MODE_WANT_BS = 3'd4,
        MODE_WANT_U  = 3'd5,
        MODE_HEX2    = 3'd6
    } jsu_mode_t;

    typedef enum logic [3:0] {
        ERR_OK          = 4'd0,
        ERR_UNTERM_STR  = 4'd1,
        ERR_RAW_CTRL    = 4'd2,
        ERR_UNTERM_ESC  = 4'd3,
        ERR_BAD_ESC     = 4'd4,
        ERR_TRUNC_HEX   = 4'd5,
        ERR_BAD_HEX     = 4'd6,
        ERR_HIGH_NO_LOW = 4'd7,
        ERR_BAD_LOW     = 4'd8,
        ERR_LONE_LOW    = 4'd9
    } jsu_err_t;

    // ASCII characters that the scanner looks for or emits
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam logic [15:0] SURR_HIGH_FIRST = 16'hD800;
    localparam logic [15:0] SURR_HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] SURR_LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] SURR_LOW_LAST   = 16'hDFFF;
    localparam logic [10:0] SUPP_PLANE_HI   = 11'd64;  // 0x10000 >> 10

    localparam logic [20:0] UTF8_LIM1 = 21'h00080;
    localparam logic [20:0] UTF8_LIM2 = 21'h00800;
    localparam logic [20:0] UTF8_LIM3 = 21'h10000;
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_LEAD4 = 8'hF0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_string;
        logic       text_ended;
    } jsu_item_t;

    typedef struct packed {
        jsu_mode_t   mode;
        logic [15:0] hex_acc;
        logic [1:0]  hex_cnt;
        logic [9:0]  high_bits;
    } jsu_state_t;

    // Results of one item: up to four bytes, or a single end-of-string entry.
    typedef struct packed {
        logic [2:0]      count;
        logic            is_end;
        jsu_err_t        err;
        logic [3:0][7:0] bytes;
    } jsu_res_t;

endpackage

@@ rtl/jsu_stream_if.sv @@
// Valid/ready channels for the input bytes and the decoded results.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_string;
    logic       text_ended;

    modport source (output valid, output in_byte, output start_string,
                    output text_ended, input ready);
    modport sink   (input valid, input in_byte, input start_string,
                    input text_ended, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [3:0] error_code;
    logic       last_of_run;

    modport source (output valid, output out_byte, output byte_valid,
                    output string_done, output error_code, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input string_done, input error_code, input last_of_run,
                    output ready);
endinterface

@@ rtl/jsu_decode.sv @@
// Combinational step of the unescaper: state and one item in, next state and results out.
module jsu_decode (
    input  jsu_pkg::jsu_state_t state,
    input  jsu_pkg::jsu_item_t  item,
    output jsu_pkg::jsu_state_t state_next,
    output jsu_pkg::jsu_res_t   res
);

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        // bit 4 set: valid digit, bits 3:0 the value
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    function automatic jsu_pkg::jsu_res_t utf8(input logic [20:0] cp);
        jsu_pkg::jsu_res_t r;
        r = '0;
        r.err = jsu_pkg::ERR_OK;
        if (cp < jsu_pkg::UTF8_LIM1) begin
            r.count    = 3'd1;
            r.bytes[0] = cp[7:0];
        end
        else if (cp < jsu_pkg::UTF8_LIM2) begin
            r.count    = 3'd2;
            r.bytes[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]};
            r.bytes[1] = jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]};
        end
        else if (cp < jsu_pkg::UTF8_LIM3) begin
            r.count    = 3'd3;
            r.bytes[0] = jsu_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]};
            r.bytes[1] = jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]};
            r.bytes[2] = jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]};
        end
        else begin
            r.count    = 3'd4;
            r.bytes[0] = jsu_pkg::UTF8_LEAD4 | {5'b00000, cp[20:18]};
            r.bytes[1] = jsu_pkg::UTF8_CONT | {2'b00, cp[17:12]};
            r.bytes[2] = jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]};
            r.bytes[3] = jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]};
        end
        return r;
    endfunction

    function automatic jsu_pkg::jsu_res_t end_res(input jsu_pkg::jsu_err_t e);
        jsu_pkg::jsu_res_t r;
        r        = '0;
        r.count  = 3'd1;
        r.is_end = 1'b1;
        r.err    = e;
        return r;
    endfunction

    function automatic jsu_pkg::jsu_res_t one_byte(input logic [7:0] b);
        jsu_pkg::jsu_res_t r;
        r          = '0;
        r.err      = jsu_pkg::ERR_OK;
        r.count    = 3'd1;
        r.bytes[0] = b;
        return r;
    endfunction

    logic [4:0]  hd;
    logic [15:0] acc_step;
    logic        is_high;
    logic        is_low;
    logic [20:0] pair_cp;

    assign hd       = hex_digit(item.in_byte);
    assign acc_step = {state.hex_acc[11:0], hd[3:0]};
    assign is_high  = acc_step >= jsu_pkg::SURR_HIGH_FIRST && acc_step <= jsu_pkg::SURR_HIGH_LAST;
    assign is_low   = acc_step >= jsu_pkg::SURR_LOW_FIRST && acc_step <= jsu_pkg::SURR_LOW_LAST;
    assign pair_cp  = {11'(state.high_bits) + jsu_pkg::SUPP_PLANE_HI, acc_step[9:0]};

    always_comb
    begin
        state_next = state;
        res        = '0;
        res.err    = jsu_pkg::ERR_OK;
        if (item.text_ended) begin
            state_next.mode = jsu_pkg::MODE_IDLE;
            unique case (state.mode)
                jsu_pkg::MODE_STR:     res = end_res(jsu_pkg::ERR_UNTERM_STR);
                jsu_pkg::MODE_ESC:     res = end_res(jsu_pkg::ERR_UNTERM_ESC);
                jsu_pkg::MODE_HEX1,
                jsu_pkg::MODE_HEX2:    res = end_res(jsu_pkg::ERR_TRUNC_HEX);
                jsu_pkg::MODE_WANT_BS,
                jsu_pkg::MODE_WANT_U:  res = end_res(jsu_pkg::ERR_HIGH_NO_LOW);
                default:               res = '0;
            endcase
        end
        else if (item.start_string) begin
            // drop any string in progress and open a new one
            state_next.mode      = jsu_pkg::MODE_STR;
            state_next.hex_acc   = '0;
            state_next.hex_cnt   = '0;
            state_next.high_bits = '0;
        end
        else begin
            unique case (state.mode)
                jsu_pkg::MODE_STR: begin
                    if (item.in_byte == jsu_pkg::CH_QUOTE) begin
                        state_next.mode = jsu_pkg::MODE_IDLE;
                        res = end_res(jsu_pkg::ERR_OK);
                    end
                    else if (item.in_byte == jsu_pkg::CH_BSLASH) begin
                        state_next.mode = jsu_pkg::MODE_ESC;
                    end
                    else if (item.in_byte < jsu_pkg::CH_SPACE) begin
                        state_next.mode = jsu_pkg::MODE_IDLE;
                        res = end_res(jsu_pkg::ERR_RAW_CTRL);
                    end
                    else begin
                        res = one_byte(item.in_byte);
                    end
                end
                jsu_pkg::MODE_ESC: begin
                    state_next.mode = jsu_pkg::MODE_STR;
                    unique case (item.in_byte)
                        jsu_pkg::CH_QUOTE:  res = one_byte(jsu_pkg::CH_QUOTE);
                        jsu_pkg::CH_BSLASH: res = one_byte(jsu_pkg::CH_BSLASH);
                        jsu_pkg::CH_SLASH:  res = one_byte(jsu_pkg::CH_SLASH);
                        jsu_pkg::CH_LC_B:   res = one_byte(jsu_pkg::CH_BS);
                        jsu_pkg::CH_LC_F:   res = one_byte(jsu_pkg::CH_FF);
                        jsu_pkg::CH_LC_N:   res = one_byte(jsu_pkg::CH_LF);
                        jsu_pkg::CH_LC_R:   res = one_byte(jsu_pkg::CH_CR);
                        jsu_pkg::CH_LC_T:   res = one_byte(jsu_pkg::CH_TAB);
                        jsu_pkg::CH_LC_U: begin
                            state_next.mode    = jsu_pkg::MODE_HEX1;
                            state_next.hex_acc = '0;
                            state_next.hex_cnt = '0;
                        end
                        default: begin
                            state_next.mode = jsu_pkg::MODE_IDLE;
                            res = end_res(jsu_pkg::ERR_BAD_ESC);
                        end
                    endcase
                end
                jsu_pkg::MODE_HEX1,
                jsu_pkg::MODE_HEX2: begin
                    if (!hd[4]) begin
                        state_next.mode = jsu_pkg::MODE_IDLE;
                        res = end_res(jsu_pkg::ERR_BAD_HEX);
                    end
                    else begin
                        state_next.hex_acc = acc_step;
                        if (state.hex_cnt != 2'd3) begin
                            state_next.hex_cnt = state.hex_cnt + 2'd1;
                        end
                        else begin
                            state_next.hex_cnt = '0;
                            if (state.mode == jsu_pkg::MODE_HEX1) begin
                                if (is_high) begin
                                    state_next.high_bits = acc_step[9:0];
                                    state_next.mode      = jsu_pkg::MODE_WANT_BS;
                                end
                                else if (is_low) begin
                                    state_next.mode = jsu_pkg::MODE_IDLE;
                                    res = end_res(jsu_pkg::ERR_LONE_LOW);
                                end
                                else begin
                                    state_next.mode = jsu_pkg::MODE_STR;
                                    res = utf8({5'd0, acc_step});
                                end
                            end
                            else if (!is_low) begin
                                state_next.mode = jsu_pkg::MODE_IDLE;
                                res = end_res(jsu_pkg::ERR_BAD_LOW);
                            end
                            else begin
                                state_next.mode = jsu_pkg::MODE_STR;
                                res = utf8(pair_cp);
                            end
                        end
                    end
                end
                jsu_pkg::MODE_WANT_BS: begin
                    if (item.in_byte != jsu_pkg::CH_BSLASH) begin
                        state_next.mode = jsu_pkg::MODE_IDLE;
                        res = end_res(jsu_pkg::ERR_HIGH_NO_LOW);
                    end
                    else begin
                        state_next.mode = jsu_pkg::MODE_WANT_U;
                    end
                end
                jsu_pkg::MODE_WANT_U: begin
                    if (item.in_byte != jsu_pkg::CH_LC_U) begin
                        state_next.mode = jsu_pkg::MODE_IDLE;
                        res = end_res(jsu_pkg::ERR_HIGH_NO_LOW);
                    end
                    else begin
                        state_next.mode    = jsu_pkg::MODE_HEX2;
                        state_next.hex_acc = '0;
                        state_next.hex_cnt = '0;
                    end
                end
                default: begin
                    // idle: ignore stray bytes
                    state_next = state;
                end
            endcase
        end
    end

endmodule

@@ rtl/jsu_burst.sv @@
// Result register: holds the results of one item and hands them out one per request.
`include "json_string_unescape_utf8_macros.svh"

module jsu_burst (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  jsu_pkg::jsu_res_t load_res,
    output logic              free,
    jsu_out_if.source         out_ch
);

    logic [3:0][7:0]  bytes_reg;
    logic [2:0]       rem_reg;
    logic [1:0]       idx_reg;
    logic             end_reg;
    jsu_pkg::jsu_err_t err_reg;
    logic             fire;

    assign fire = out_ch.valid && out_ch.ready;
    // empty next cycle: nothing held, or the last entry leaves now
    assign free = (rem_reg == 3'd0) || (rem_reg == 3'd1 && out_ch.ready);

    assign out_ch.valid       = rem_reg != 3'd0;
    assign out_ch.out_byte    = end_reg ? 8'd0 : bytes_reg[idx_reg];
    assign out_ch.byte_valid  = !end_reg;
    assign out_ch.string_done = end_reg;
    assign out_ch.error_code  = end_reg ? err_reg : jsu_pkg::ERR_OK;
    assign out_ch.last_of_run = rem_reg == 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rem_reg <= '0;
            idx_reg <= '0;
            end_reg <= 1'b0;
            err_reg <= jsu_pkg::ERR_OK;
        end
        else if (load) begin
            rem_reg <= load_res.count;
            idx_reg <= '0;
            end_reg <= load_res.is_end;
            err_reg <= load_res.err;
        end
        else if (fire) begin
            rem_reg <= rem_reg - 3'd1;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            bytes_reg <= load_res.bytes;
    end

    `JSU_ASSERT_NOW(a_load_when_free, load, free, "result register overwritten while busy")
    `JSU_ASSERT_NOW(a_rem_range, 1'b1, rem_reg <= 3'd4, "more than four results held")
    `JSU_ASSERT_NOW(a_end_single, out_ch.valid && end_reg, rem_reg == 3'd1,
                    "end of string not a single result")
    `JSU_ASSERT_NEXT(a_drain_step, fire && !load && rem_reg > 3'd1,
                     rem_reg == $past(rem_reg) - 3'd1 && idx_reg == $past(idx_reg) + 2'd1,
                     "result register drained out of order")

endmodule

@@ rtl/json_string_unescape_utf8.sv @@
// Top level of the JSON string unescaper with UTF-8 output.
// JSON string unescaper. Feed the text one byte per request on in_ch: the request
// with start_string set is the opening quote, a request with text_ended set marks
// the end of the text. Plain bytes pass through, the escapes \" \\ \/ \b \f \n \r \t
// and \uXXXX (with surrogate pairs) are decoded to UTF-8, and each string ends with
// one request on out_ch with string_done set and the error code (0 for a closing
// quote); a string dropped by a new start_string gives none. Rate: one input
// request per cycle unless a request with results waits on the result register.
// A request travels through an input register, one pass of decode logic and the
// result register. An escape that completes a code point yields up to four
// results, which the result register hands out one per cycle while out_ch is
// ready; while it drains, requests that give no result (escape and hex digits)
// keep flowing in, and a request with results waits only until the register's
// last entry leaves. Sustained throughput is one byte per cycle, set by out_ch.
module json_string_unescape_utf8 (
    input  logic     clk,
    input  logic     rst_n,
    jsu_in_if.sink   in_ch,
    jsu_out_if.source out_ch
);

    // input register
    logic                s1_valid_reg;
    jsu_pkg::jsu_item_t  s1_item_reg;

    // scanner state
    jsu_pkg::jsu_state_t state_reg;
    jsu_pkg::jsu_state_t state_next;

    jsu_pkg::jsu_res_t   dec_res;
    logic                burst_free;
    logic                s1_go;
    logic                in_fire;

    jsu_decode u_decode (
        .state      (state_reg),
        .item       (s1_item_reg),
        .state_next (state_next),
        .res        (dec_res)
    );

    // advance the held request when it gives no result or the result register
    // can take its results
    assign s1_go   = s1_valid_reg && (dec_res.count == 3'd0 || burst_free);
    assign in_fire = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !s1_valid_reg || s1_go;

    jsu_burst u_burst (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (s1_go && dec_res.count != 3'd0),
        .load_res (dec_res),
        .free     (burst_free),
        .out_ch   (out_ch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            state_reg    <= '{mode: jsu_pkg::MODE_IDLE, hex_acc: '0, hex_cnt: '0,
                              high_bits: '0};
        end
        else begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;
            // commit the decode pass
            if (s1_go)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            s1_item_reg.in_byte      <= in_ch.in_byte;
            s1_item_reg.start_string <= in_ch.start_string;
            s1_item_reg.text_ended   <= in_ch.text_ended;
        end
    end

endmodule

@@ test/tb_json_string_unescape_utf8.sv @@
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
module tb_json_string_unescape_utf8;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    // One decoded result as it should leave the block.
    typedef struct {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        jsu_err_t   error_code;
        logic       last_of_run;
    } unescaped_t;

    // How a directed row is checked: by the decoder model, by a result typed in, or as giving no result.
    typedef enum logic [1:0] {
        CK_MODEL,
        CK_SILENT,
        CK_BYTE,
        CK_END
    } check_kind_t;

    typedef struct {
        jsu_item_t   req;
        check_kind_t kind;
        logic [7:0]  lit_byte;
        jsu_err_t    lit_err;
    } directed_row_t;

    logic clk;
    logic rst_n;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    json_string_unescape_utf8 u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Idle rates in percent; the stimulus process moves them between phases.
    int send_idle_pct = 14;
    int recv_idle_pct = 69;
    int error_count   = 0;

    // Decoded results still owed by the block, oldest first.
    unescaped_t unescaped_due[$];
    // Results of the request being decoded by the model.
    unescaped_t step_out[$];
    // Requests of the string being built by the random generator.
    jsu_item_t  string_reqs[$];
    directed_row_t directed_rows[$];

    // Decoder model state.
    jsu_mode_t   cur_mode  = MODE_IDLE;
    logic [15:0] hex_acc   = '0;
    logic [1:0]  hex_taken = '0;
    logic [9:0]  high_bits = '0;

    logic [7:0] escape_chars [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LC_B,
                                     CH_LC_F, CH_LC_N, CH_LC_R, CH_LC_T};

    //------------------------------------------------------------------
    // Clock and run limit
    //------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stop the run far beyond the slowest correct run.
    initial
    begin
        #2ms;
        $display("FAIL");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("%0t ns: ERROR %s", $realtime, msg);
        error_count++;
    endtask

    //------------------------------------------------------------------
    // Decoder model
    //------------------------------------------------------------------
    function automatic void emit_byte(input logic [7:0] b);
        step_out.insert(step_out.size(), '{b, 1'b1, 1'b0, ERR_OK, 1'b0});
    endfunction

    // Close the string: one end entry carrying the error code, back to idle.
    function automatic void close_string(input jsu_err_t e);
        cur_mode = MODE_IDLE;
        step_out.insert(step_out.size(), '{8'h00, 1'b0, 1'b1, e, 1'b0});
    endfunction

    function automatic void emit_utf8(input logic [20:0] cp);
        if (cp < UTF8_LIM1)
        begin
            emit_byte(cp[7:0]);
        end
        else if (cp < UTF8_LIM2)
        begin
            emit_byte(UTF8_LEAD2 | {3'b000, cp[10:6]});
            emit_byte(UTF8_CONT | {2'b00, cp[5:0]});
        end
        else if (cp < UTF8_LIM3)
        begin
            emit_byte(UTF8_LEAD3 | {4'b0000, cp[15:12]});
            emit_byte(UTF8_CONT | {2'b00, cp[11:6]});
            emit_byte(UTF8_CONT | {2'b00, cp[5:0]});
        end
        else
        begin
            emit_byte(UTF8_LEAD4 | {5'b00000, cp[20:18]});
            emit_byte(UTF8_CONT | {2'b00, cp[17:12]});
            emit_byte(UTF8_CONT | {2'b00, cp[11:6]});
            emit_byte(UTF8_CONT | {2'b00, cp[5:0]});
        end
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    // One hex digit of a \u run; the fourth digit completes a code unit.
    function automatic void take_hex_digit(input logic [7:0] c);
        int          d;
        logic [15:0] unit;
        d = hex_nibble(c);
        if (d < 0)
        begin
            close_string(ERR_BAD_HEX);
            return;
        end
        hex_acc = {hex_acc[11:0], d[3:0]};
        if (hex_taken != 2'd3)
        begin
            hex_taken++;
            return;
        end
        hex_taken = '0;
        unit = hex_acc;
        if (cur_mode == MODE_HEX1)
        begin
            if (unit >= SURR_HIGH_FIRST && unit <= SURR_HIGH_LAST)
            begin
                // hold the high half and wait for the low escape
                high_bits = unit[9:0];
                cur_mode  = MODE_WANT_BS;
            end
            else if (unit >= SURR_LOW_FIRST && unit <= SURR_LOW_LAST)
            begin
                close_string(ERR_LONE_LOW);
            end
            else
            begin
                cur_mode = MODE_STR;
                emit_utf8({5'd0, unit});
            end
        end
        else if (unit < SURR_LOW_FIRST || unit > SURR_LOW_LAST)
        begin
            close_string(ERR_BAD_LOW);
        end
        else
        begin
            cur_mode = MODE_STR;
            emit_utf8(UTF8_LIM3 + {1'b0, high_bits, unit[9:0]});
        end
    endfunction

    // Advance the model by one accepted request; its results land in step_out.
    function automatic void unescape_step(input jsu_item_t req);
        logic [7:0] c;
        step_out.delete();
        c = req.in_byte;
        if (req.text_ended)
        begin
            // the end marker wins over start_string
            case (cur_mode)
                MODE_STR:                   close_string(ERR_UNTERM_STR);
                MODE_ESC:                   close_string(ERR_UNTERM_ESC);
                MODE_HEX1, MODE_HEX2:       close_string(ERR_TRUNC_HEX);
                MODE_WANT_BS, MODE_WANT_U:  close_string(ERR_HIGH_NO_LOW);
                default:                    cur_mode = MODE_IDLE;
            endcase
        end
        else if (req.start_string)
        begin
            // drop any string in progress without a result
            cur_mode  = MODE_STR;
            hex_acc   = '0;
            hex_taken = '0;
            high_bits = '0;
        end
        else
        begin
            case (cur_mode)
                MODE_STR:
                begin
                    if (c == CH_QUOTE)
                        close_string(ERR_OK);
                    else if (c == CH_BSLASH)
                        cur_mode = MODE_ESC;
                    else if (c < CH_SPACE)
                        close_string(ERR_RAW_CTRL);
                    else
                        emit_byte(c);
                end
                MODE_ESC:
                begin
                    cur_mode = MODE_STR;
                    case (c)
                        CH_QUOTE:  emit_byte(CH_QUOTE);
                        CH_BSLASH: emit_byte(CH_BSLASH);
                        CH_SLASH:  emit_byte(CH_SLASH);
                        CH_LC_B:   emit_byte(CH_BS);
                        CH_LC_F:   emit_byte(CH_FF);
                        CH_LC_N:   emit_byte(CH_LF);
                        CH_LC_R:   emit_byte(CH_CR);
                        CH_LC_T:   emit_byte(CH_TAB);
                        CH_LC_U:
                        begin
                            cur_mode  = MODE_HEX1;
                            hex_acc   = '0;
                            hex_taken = '0;
                        end
                        default:   close_string(ERR_BAD_ESC);
                    endcase
                end
                MODE_HEX1, MODE_HEX2:
                begin
                    take_hex_digit(c);
                end
                MODE_WANT_BS:
                begin
                    if (c != CH_BSLASH)
                        close_string(ERR_HIGH_NO_LOW);
                    else
                        cur_mode = MODE_WANT_U;
                end
                MODE_WANT_U:
                begin
                    if (c != CH_LC_U)
                    begin
                        close_string(ERR_HIGH_NO_LOW);
                    end
                    else
                    begin
                        cur_mode  = MODE_HEX2;
                        hex_acc   = '0;
                        hex_taken = '0;
                    end
                end
                default: ;  // idle: bytes outside a string are dropped
            endcase
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last_of_run = 1'b1;
    endfunction

    //------------------------------------------------------------------
    // Input side: one request per call, with random idle cycles before it
    //------------------------------------------------------------------
    task automatic send_request(input jsu_item_t req, input check_kind_t kind,
                                input logic [7:0] lit_byte, input jsu_err_t lit_err);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.in_byte      <= req.in_byte;
        in_ch.start_string <= req.start_string;
        in_ch.text_ended   <= req.text_ended;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        // request taken at this edge: advance the model, then book what is owed
        unescape_step(req);
        case (kind)
            CK_MODEL:
                foreach (step_out[i])
                    unescaped_due.insert(unescaped_due.size(), step_out[i]);
            CK_BYTE:
                unescaped_due.insert(unescaped_due.size(),
                                     '{lit_byte, 1'b1, 1'b0, ERR_OK, 1'b1});
            CK_END:
                unescaped_due.insert(unescaped_due.size(),
                                     '{8'h00, 1'b0, 1'b1, lit_err, 1'b1});
            default: ;
        endcase
    endtask

    //------------------------------------------------------------------
    // Output side: random stalls, compare every taken result
    //------------------------------------------------------------------
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        unescaped_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (unescaped_due.size() == 0)
            begin
                flag_error($sformatf("unexpected result byte=%02h done=%0b err=%0d",
                                     out_ch.out_byte, out_ch.string_done,
                                     out_ch.error_code));
            end
            else
            begin
                want = unescaped_due.pop_front();
                if (out_ch.out_byte !== want.out_byte)
                    flag_error($sformatf("out_byte %02h, want %02h",
                                         out_ch.out_byte, want.out_byte));
                if (out_ch.byte_valid !== want.byte_valid)
                    flag_error($sformatf("byte_valid %0b, want %0b",
                                         out_ch.byte_valid, want.byte_valid));
                if (out_ch.string_done !== want.string_done)
                    flag_error($sformatf("string_done %0b, want %0b",
                                         out_ch.string_done, want.string_done));
                if (out_ch.error_code !== want.error_code)
                    flag_error($sformatf("error_code %0d, want %0d",
                                         out_ch.error_code, want.error_code));
                if (out_ch.last_of_run !== want.last_of_run)
                    flag_error($sformatf("last_of_run %0b, want %0b",
                                         out_ch.last_of_run, want.last_of_run));
            end
        end
    end

    //------------------------------------------------------------------
    // Random string generator
    //------------------------------------------------------------------
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + {4'h0, n};
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        string_reqs.insert(string_reqs.size(), '{b, 1'b0, 1'b0});
    endfunction

    // End marker: the byte is ignored, start_string rides along at random.
    function automatic void put_end();
        string_reqs.insert(string_reqs.size(), '{8'($urandom), 1'($urandom), 1'b1});
    endfunction

    function automatic void put_u_escape(input logic [15:0] v);
        put_byte(CH_BSLASH);
        put_byte(CH_LC_U);
        for (int i = 3; i >= 0; i--)
            put_byte(hex_char(v[i*4 +: 4]));
    endfunction

    // Non-surrogate code unit, spread over the one-, two- and three-byte forms.
    function automatic logic [15:0] bmp_unit();
        int r;
        case ($urandom_range(0, 2))
            0: r = $urandom_range(0, 16'h7F);
            1: r = $urandom_range(16'h80, 16'h7FF);
            default:
            begin
                r = $urandom_range(16'h800, 16'hF7FF);
                if (r >= SURR_HIGH_FIRST)
                    r += 16'h800;
            end
        endcase
        return 16'(r);
    endfunction

    function automatic logic [15:0] high_unit();
        return 16'($urandom_range(SURR_HIGH_FIRST, SURR_HIGH_LAST));
    endfunction

    function automatic logic [15:0] low_unit();
        return 16'($urandom_range(SURR_LOW_FIRST, SURR_LOW_LAST));
    endfunction

    // Build one string: opening quote, random well-formed content, then mostly a
    // closing quote and otherwise one of the ways a string can break.
    task automatic queue_string();
        logic [7:0]  b;
        logic [15:0] v;
        string_reqs.insert(string_reqs.size(), '{8'($urandom), 1'b1, 1'b0});
        repeat ($urandom_range(0, 6))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    do b = 8'($urandom_range(CH_SPACE, 255));
                    while (b == CH_QUOTE || b == CH_BSLASH);
                    put_byte(b);
                end
                4, 5:
                begin
                    put_byte(CH_BSLASH);
                    put_byte(escape_chars[$urandom_range(0, 7)]);
                end
                6, 7:
                    put_u_escape(bmp_unit());
                default:
                begin
                    put_u_escape(high_unit());
                    put_u_escape(low_unit());
                end
            endcase
        end
        case ($urandom_range(0, 19))
            10: put_end();
            11: put_byte(8'($urandom_range(0, CH_SPACE - 1)));
            12:
            begin
                put_byte(CH_BSLASH);
                put_byte(8'($urandom));
            end
            13:
            begin
                put_byte(CH_BSLASH);
                put_end();
            end
            14, 15:
            begin
                put_byte(CH_BSLASH);
                put_byte(CH_LC_U);
                repeat ($urandom_range(0, 3))
                    put_byte(hex_char(4'($urandom)));
                if ($urandom_range(0, 1))
                begin
                    do b = 8'($urandom);
                    while (hex_nibble(b) >= 0);
                    put_byte(b);
                end
                else
                begin
                    put_end();
                end
            end
            16:
            begin
                // high half not followed by a low escape
                put_u_escape(high_unit());
                case ($urandom_range(0, 3))
                    0: put_byte(8'($urandom));
                    1:
                    begin
                        put_byte(CH_BSLASH);
                        put_byte(8'($urandom));
                    end
                    2: put_end();
                    default:
                    begin
                        put_byte(CH_BSLASH);
                        put_end();
                    end
                endcase
            end
            17:
            begin
                put_u_escape(high_unit());
                do v = 16'($urandom);
                while (v >= SURR_LOW_FIRST && v <= SURR_LOW_LAST);
                put_u_escape(v);
            end
            18: put_u_escape(low_unit());
            19:
            begin
                // restart mid-string, then close the new one
                string_reqs.insert(string_reqs.size(), '{8'($urandom), 1'b1, 1'b0});
                put_byte(CH_QUOTE);
            end
            default: put_byte(CH_QUOTE);
        endcase
    endtask

    function automatic void add_row(input logic [7:0] b, input logic s, input logic e,
                                    input check_kind_t k, input logic [7:0] lb = 8'h00,
                                    input jsu_err_t le = ERR_OK);
        directed_rows.insert(directed_rows.size(), '{'{b, s, e}, k, lb, le});
    endfunction

    //------------------------------------------------------------------
    // Stimulus
    //------------------------------------------------------------------
    initial
    begin
        int taken;
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.in_byte      = 8'h00;
        in_ch.start_string = 1'b0;
        in_ch.text_ended   = 1'b0;

        // Directed rows: idle inputs, byte extremes, a start that drops a string,
        // the largest surrogate pair, and the simple error endings.
        add_row(8'h00, 1'b0, 1'b1, CK_SILENT);                   // end marker while idle
        add_row(8'h00, 1'b0, 1'b0, CK_SILENT);                   // byte while idle
        add_row(CH_QUOTE, 1'b1, 1'b0, CK_SILENT);
        add_row(CH_SPACE, 1'b0, 1'b0, CK_BYTE, CH_SPACE);        // lowest plain byte
        add_row(8'hFF, 1'b0, 1'b0, CK_BYTE, 8'hFF);              // highest plain byte
        add_row(CH_QUOTE, 1'b1, 1'b0, CK_SILENT);                // restart drops the string
        add_row(8'h1F, 1'b0, 1'b0, CK_END, 8'h00, ERR_RAW_CTRL);
        add_row(CH_QUOTE, 1'b1, 1'b1, CK_SILENT);                // end marker beats start
        add_row(CH_QUOTE, 1'b1, 1'b0, CK_SILENT);
        add_row(CH_BSLASH, 1'b0, 1'b0, CK_MODEL);                // \uDBFF\udffF: U+10FFFF
        add_row(CH_LC_U, 1'b0, 1'b0, CK_MODEL);
        add_row(8'h44, 1'b0, 1'b0, CK_MODEL);
        add_row(8'h42, 1'b0, 1'b0, CK_MODEL);
        add_row(8'h46, 1'b0, 1'b0, CK_MODEL);
        add_row(8'h46, 1'b0, 1'b0, CK_MODEL);
        add_row(CH_BSLASH, 1'b0, 1'b0, CK_MODEL);
        add_row(CH_LC_U, 1'b0, 1'b0, CK_MODEL);
        add_row(8'h64, 1'b0, 1'b0, CK_MODEL);
        add_row(8'h66, 1'b0, 1'b0, CK_MODEL);
        add_row(8'h66, 1'b0, 1'b0, CK_MODEL);
        add_row(8'h46, 1'b0, 1'b0, CK_MODEL);
        add_row(CH_QUOTE, 1'b0, 1'b0, CK_END, 8'h00, ERR_OK);
        add_row(CH_QUOTE, 1'b1, 1'b0, CK_SILENT);
        add_row(CH_BSLASH, 1'b0, 1'b0, CK_SILENT);
        add_row(8'h71, 1'b0, 1'b0, CK_END, 8'h00, ERR_BAD_ESC);
        add_row(CH_QUOTE, 1'b1, 1'b0, CK_SILENT);
        add_row(CH_BSLASH, 1'b0, 1'b0, CK_SILENT);
        add_row(8'hAA, 1'b0, 1'b1, CK_END, 8'h00, ERR_UNTERM_ESC);
        add_row(CH_QUOTE, 1'b1, 1'b0, CK_SILENT);
        add_row(8'h55, 1'b1, 1'b1, CK_END, 8'h00, ERR_UNTERM_STR);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].kind,
                         directed_rows[i].lit_byte, directed_rows[i].lit_err);

        // Three random phases: slow receiver, slow sender, then no idling at all.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 14;
                    recv_idle_pct = 69;
                end
                1:
                begin
                    send_idle_pct = 69;
                    recv_idle_pct = 14;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            taken = 0;
            while (taken < 64)
            begin
                // stray request between strings; not counted
                if ($urandom_range(0, 7) == 0)
                    send_request('{8'($urandom), 1'b0, 1'($urandom)}, CK_MODEL,
                                 8'h00, ERR_OK);
                queue_string();
                taken += string_reqs.size();
                while (string_reqs.size() > 0)
                    send_request(string_reqs.pop_front(), CK_MODEL, 8'h00, ERR_OK);
            end
        end

        in_ch.valid <= 1'b0;
        while (unescaped_due.size() != 0)
            @(posedge clk);
        // let any stray late result show up
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_stream_if.sv
rtl/jsu_decode.sv
rtl/jsu_burst.sv
rtl/json_string_unescape_utf8.sv
test/tb_json_string_unescape_utf8.sv
